>>> sv/rdc_pkg.sv
// Shared constants, types and helpers for the radix digit converter.
package rdc_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned MAX_DIGITS_DEF = 31;

  // Radix register
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned RADIX_RESET = 10;
  localparam int unsigned RADIX_MIN   = 2;
  localparam int unsigned RADIX_MAX   = 16;

  // Result fields
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned OUT_TDATA_W = 16;

  // Dividend bits retired per divider cycle
  localparam int unsigned CHUNK_BITS = 8;

  // ASCII codes
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  // Back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP,
    ST_LOAD
  } rdc_state_e;

  // Digit to its ASCII character, 0-9 then upper-case A-F
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DIGIT_TEN) begin
      digit_ascii = ASCII_ZERO + d_ext;
    end else begin
      digit_ascii = ASCII_A + d_ext - CHAR_W'(DIGIT_TEN);
    end
  endfunction

endpackage

>>> sv/rdc_front.sv
// Front end: radix register, radix clamping and input beat acceptance.
module rdc_front import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [RADIX_W-1:0]    cfg_data_i,
  // Input beat
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] in_value_i,
  // Push side of the queue: {radix, value}
  output logic                  push_o,
  input  logic                  full_i,
  output logic [RADIX_W+VALUE_BITS-1:0] push_data_o
);

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] radix_eff;

  // Radix register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_W'(RADIX_RESET);
    end else if (cfg_valid_i) begin
      radix_q <= cfg_data_i;
    end
  end

  // Clamp the base into 2..16
  always_comb begin
    if (radix_q < RADIX_W'(RADIX_MIN)) begin
      radix_eff = RADIX_W'(RADIX_MIN);
    end else if (radix_q > RADIX_W'(RADIX_MAX)) begin
      radix_eff = RADIX_W'(RADIX_MAX);
    end else begin
      radix_eff = radix_q;
    end
  end

  // Take a beat whenever the queue has room
  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;
  assign push_data_o = {radix_eff, in_value_i};

endmodule

>>> sv/rdc_queue.sv
// Two-entry queue between the front end and the back end.
module rdc_queue #(
  parameter int unsigned WIDTH = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/rdc_back.sv
// Back end: chunked radix divider, digit stack and most-significant-first emission.
module rdc_back import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item from the queue
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  logic [VALUE_BITS-1:0] item_value_i,
  input  logic [RADIX_W-1:0]    item_radix_i,
  // Result beat
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIGIT_W-1:0]    out_digit_o,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  out_last_o
);

  localparam int unsigned STEPS    = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned PAD_BITS = STEPS * CHUNK_BITS;
  localparam int unsigned STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW       = $clog2(MAX_DIGITS);

  rdc_state_e state_q, state_d;

  logic [PAD_BITS-1:0] work_q, work_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [RADIX_W-1:0]  radix_q, radix_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                rd_last_q, rd_last_d;
  logic [DIGIT_W-1:0]  rd_digit_q;
  logic                out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0]  out_digit_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                out_last_q;

  logic [DIGIT_W-1:0]  stack_mem [MAX_DIGITS];

  logic [PAD_BITS-1:0] div_work;
  logic [DIGIT_W-1:0]  div_rem;
  logic                digit_done;
  logic                run_done;
  logic                wr_en;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                load_out;

  // One divider cycle: CHUNK_BITS restoring steps on a narrow remainder
  always_comb begin
    logic [PAD_BITS-1:0] w;
    logic [DIGIT_W-1:0]  r;
    logic [RADIX_W-1:0]  t;
    logic                b;
    w = work_q;
    r = rem_q;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      t = {r, w[PAD_BITS-1]};
      if (t >= radix_q) begin
        t = t - radix_q;
        b = 1'b1;
      end else begin
        b = 1'b0;
      end
      r = t[DIGIT_W-1:0];
      w = {w[PAD_BITS-2:0], b};
    end
    div_work = w;
    div_rem  = r;
  end

  assign digit_done = (state_q == ST_DIV) && (step_q == STEP_W'(STEPS - 1));
  assign run_done   = (div_work == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
  assign load_out   = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);
  assign wr_en      = digit_done;
  assign rd_en      = state_q == ST_POP;
  assign rd_addr    = AW'(cnt_q - CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (digit_done && run_done) state_d = ST_POP;
      end
      ST_POP: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (load_out) state_d = rd_last_q ? ST_IDLE : ST_POP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs
  always_comb begin
    work_d      = work_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    item_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          work_d  = PAD_BITS'(item_value_i);
          rem_d   = '0;
          radix_d = item_radix_i;
          step_d  = '0;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        work_d = div_work;
        if (digit_done) begin
          rem_d  = '0;
          step_d = '0;
          cnt_d  = cnt_q + CNT_W'(1);
        end else begin
          rem_d  = div_rem;
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_POP: begin
        cnt_d     = cnt_q - CNT_W'(1);
        rd_last_d = cnt_q == CNT_W'(1);
      end
      ST_LOAD: begin
        if (load_out) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    rem_q     <= rem_d;
    radix_q   <= radix_d;
    rd_last_q <= rd_last_d;
    if (load_out) begin
      out_digit_q <= rd_digit_q;
      out_char_q  <= digit_ascii(rd_digit_q);
      out_last_q  <= rd_last_q;
    end
  end

  // Digit stack: pushed during division, popped in reverse
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[cnt_q[AW-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_digit_q <= stack_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_digit_o = out_digit_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

>>> sv/radix_digit_converter_unit.sv
// Top level: converts integers to digit beats in a configurable radix.
// Each item is divided chunk by chunk, with every digit pushed on the digit stack; the
// digits are then read back from the stack most significant first, one read per beat.
// The back end takes one item at a time through the shared chunked divider and the
// registered stack read; a queued item waits until the current run ends.
// Reset: radix returns to 10, queue and sequencer empty; the digit stack is not cleared.
module radix_digit_converter_unit import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [RADIX_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,  // value
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // digit_value, digit_char
  output logic                   m_axis_tlast   // last_digit
);

  localparam int unsigned ITEM_W = RADIX_W + VALUE_BITS;

  logic              q_push;
  logic              q_full;
  logic [ITEM_W-1:0] q_push_data;
  logic              q_valid;
  logic              q_pop;
  logic [ITEM_W-1:0] q_pop_data;
  logic              back_ready;
  logic [DIGIT_W-1:0] out_digit;
  logic [CHAR_W-1:0]  out_char;

  rdc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata[VALUE_BITS-1:0]),
    .push_o     (q_push),
    .full_i     (q_full),
    .push_data_o(q_push_data)
  );

  rdc_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_pop_data)
  );

  assign q_pop = q_valid && back_ready;

  rdc_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(back_ready),
    .item_value_i(q_pop_data[VALUE_BITS-1:0]),
    .item_radix_i(q_pop_data[ITEM_W-1:VALUE_BITS]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_digit_o (out_digit),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - DIGIT_W - CHAR_W){1'b0}}, out_char, out_digit};

  // Character always matches the digit it travels with
  a_char_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_char == digit_ascii(out_digit)))
    else $error("digit character does not match digit value");

  // Queued items carry a clamped base
  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> (q_pop_data[ITEM_W-1:VALUE_BITS] >= RADIX_W'(RADIX_MIN)) &&
                (q_pop_data[ITEM_W-1:VALUE_BITS] <= RADIX_W'(RADIX_MAX)))
    else $error("queued radix outside 2..16");

  // A queue push is only made with room left
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !q_pop |=> q_full)
    else $error("queue lost an entry while full");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the radix digit converter: directed table plus random phases.
`timescale 1ns / 100ps

module tb_top;
  import rdc_pkg::*;

  localparam int unsigned VALUE_W    = VALUE_BITS_DEF;
  localparam int unsigned DIGITS_MAX = MAX_DIGITS_DEF;
  localparam int unsigned IN_TDATA_W = ((VALUE_W + 7) / 8) * 8;
  localparam int          KEEP_RADIX = -1;
  localparam int          N_DIRECTED = 22;
  localparam int          N_PHASES   = 10;
  localparam int          PHASE_LEN  = 47;
  localparam int          IDLE_PCT   = 37;
  localparam int          SETTLE_CYC = 12;
  localparam int          MAX_REPORT = 10;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // One digit beat as it leaves the block
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  char_code;
    logic               last;
  } digit_beat_t;

  // Directed row: optional radix write, value, and digit text where it is obvious
  typedef struct {
    int                 set_radix;
    logic [VALUE_W-1:0] value;
    string              text;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [RADIX_W-1:0]     cfg_data_i  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // digit_value, digit_char
  logic                   m_axis_tlast;         // last_digit

  logic [RADIX_W-1:0] radix_setting = RADIX_W'(RADIX_RESET);
  digit_beat_t        pending_digits[$];
  int                 mismatch_count = 0;
  bit                 no_idle = 1'b0;

  radix_digit_converter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Directed stimulus; empty text means the row is checked against the predictor
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{KEEP_RADIX, 31'd0,          "0"},
    '{KEEP_RADIX, 31'h7FFFFFFF,   "2147483647"},
    '{KEEP_RADIX, 31'd9,          "9"},
    '{KEEP_RADIX, 31'd1234567890, ""},
    '{16,         31'h7FFFFFFF,   "7FFFFFFF"},
    '{KEEP_RADIX, 31'h0ABCDEF9,   "ABCDEF9"},
    '{KEEP_RADIX, 31'd0,          "0"},
    '{2,          31'h7FFFFFFF,   "1111111111111111111111111111111"},
    '{KEEP_RADIX, 31'd1,          "1"},
    '{KEEP_RADIX, 31'h40000000,   "1000000000000000000000000000000"},
    '{0,          31'd5,          "101"},
    '{1,          31'd6,          "110"},
    '{17,         31'd255,        "FF"},
    '{31,         31'h0000DEAD,   "DEAD"},
    '{3,          31'h7FFFFFFF,   ""},
    '{7,          31'd48,         "66"},
    '{11,         31'd120,        "AA"},
    '{15,         31'd224,        "EE"},
    '{15,         31'h7FFFFFFF,   ""},
    '{10,         31'd1000000000, "1000000000"},
    '{16,         31'h55555555,   "55555555"},
    '{KEEP_RADIX, 31'h2AAAAAAA,   "2AAAAAAA"}
  };

  // Predictor: repeated division by the clamped radix, digits popped MSB first
  function automatic void convert_to_digits(input logic [VALUE_W-1:0] value);
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] digit_stack [DIGITS_MAX];
    logic [VALUE_W-1:0] quotient;
    digit_beat_t        beat;
    int                 count;
    base = radix_setting;
    if (base < RADIX_W'(RADIX_MIN)) base = RADIX_W'(RADIX_MIN);
    if (base > RADIX_W'(RADIX_MAX)) base = RADIX_W'(RADIX_MAX);
    quotient = value;
    count    = 0;
    do begin
      digit_stack[count] = DIGIT_W'(quotient % base);
      count++;
      quotient = quotient / base;
    end while (quotient != '0 && count < DIGITS_MAX);
    while (count > 0) begin
      count--;
      beat.digit     = digit_stack[count];
      beat.char_code = (beat.digit < DIGIT_TEN) ? ASCII_ZERO + CHAR_W'(beat.digit)
                                                : ASCII_A + CHAR_W'(beat.digit - DIGIT_TEN);
      beat.last      = (count == 0);
      pending_digits.push_back(beat);
    end
  endfunction

  // Expected beats from typed digit text
  function automatic void queue_digit_text(input string text);
    digit_beat_t beat;
    byte         c;
    for (int i = 0; i < text.len(); i++) begin
      c              = text[i];
      beat.char_code = CHAR_W'(c);
      beat.digit     = (c >= ASCII_A) ? DIGIT_W'(c - ASCII_A + DIGIT_TEN)
                                      : DIGIT_W'(c - ASCII_ZERO);
      beat.last      = (i == text.len() - 1);
      pending_digits.push_back(beat);
    end
  endfunction

  // Drive one value beat; expectations are queued at the accepting edge
  task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(value);
    do @(posedge clk_i); while (!s_axis_tready);
    if (text.len() != 0) queue_digit_text(text);
    else convert_to_digits(value);
  endtask

  // Radix write, only once the block has drained
  task automatic write_radix(input logic [RADIX_W-1:0] radix);
    s_axis_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= radix;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    radix_setting  = radix;
  endtask

  // Output side backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each digit beat with the oldest expectation
  always @(posedge clk_i) begin
    digit_beat_t got;
    digit_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.digit     = m_axis_tdata[DIGIT_W-1:0];
      got.char_code = m_axis_tdata[DIGIT_W +: CHAR_W];
      got.last      = m_axis_tlast;
      if (pending_digits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT)
          $display("%0t: unexpected beat digit=%0d char=%0d last=%0b",
                   $realtime, got.digit, got.char_code, got.last);
      end else begin
        want = pending_digits.pop_front();
        if (got.digit !== want.digit || got.char_code !== want.char_code ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORT)
            $display("%0t: beat mismatch digit %0d/%0d char %0d/%0d last %0b/%0b (exp/act)",
                     $realtime, want.digit, got.digit, want.char_code, got.char_code,
                     want.last, got.last);
        end
      end
    end
  end

  // Main sequence
  initial begin
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_radix != KEEP_RADIX)
        write_radix(RADIX_W'(directed_rows[i].set_radix));
      send_value(directed_rows[i].value, directed_rows[i].text);
    end

    // random phases, each with its own radix; two phases run without idling
    for (int phase = 0; phase < N_PHASES; phase++) begin
      radix = ($urandom_range(0, 3) == 0) ? RADIX_W'($urandom_range(0, 31))
                                          : RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      write_radix(radix);
      no_idle = (phase == 4 || phase == 5);
      for (int n = 0; n < PHASE_LEN; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: value = VALUE_W'($urandom());
          4, 5, 6:    value = VALUE_W'($urandom_range(0, 1000));
          7, 8:       value = VALUE_W'($urandom()) >> $urandom_range(0, VALUE_W - 1);
          default: begin
            case ($urandom_range(0, 2))
              0:       value = '0;
              1:       value = VALUE_W'(1);
              default: value = VALUE_MAX;
            endcase
          end
        endcase
        send_value(value, "");
      end
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain and finish
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("radix_digit_converter_unit test passed");
    end else begin
      $display("radix_digit_converter_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("radix_digit_converter_unit test failed");
    $finish;
  end

endmodule

>>> files.f
sv/rdc_pkg.sv
sv/rdc_front.sv
sv/rdc_queue.sv
sv/rdc_back.sv
sv/radix_digit_converter_unit.sv
tb/sv/tb_top.sv
